// ===== rtl/core/rgba8_saturating_color_alu_top_assert.svh =====
// Assertion macros for the RGBA8 color ALU top level.
`ifndef RGBA8_SATURATING_COLOR_ALU_TOP_ASSERT_SVH
`define RGBA8_SATURATING_COLOR_ALU_TOP_ASSERT_SVH

// Same-cycle implication, sampled on clk and switched off while rst_n is low.
`define RGBA_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk and switched off while rst_n is low.
`define RGBA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/rgba8_alu_pkg.sv =====
// Shared types and constants for the RGBA8 saturating color ALU.
`timescale 1ns / 1ps

package rgba8_alu_pkg;

  localparam int unsigned CHAN_W    = 8;
  localparam int unsigned NUM_CHAN  = 4;
  localparam int unsigned SCALE_W   = 16;
  localparam int unsigned RATIO_W   = 9;
  localparam int unsigned CMD_W     = 3;
  localparam int unsigned IN_DATA_W = 96;
  localparam int unsigned OUT_DATA_W = 32;

  // Bit offsets of the packed input fields.
  localparam int unsigned A_LSB     = 0;
  localparam int unsigned B_LSB     = 32;
  localparam int unsigned SCALE_LSB = 64;
  localparam int unsigned RATIO_LSB = 80;

  localparam logic [CHAN_W-1:0] CHAN_MAX = 8'd255;

  typedef enum logic [CMD_W-1:0] {
    CMD_ADD   = 3'd0,
    CMD_SUB   = 3'd1,
    CMD_MOD   = 3'd2,
    CMD_SCALE = 3'd3,
    CMD_BLEND = 3'd4
  } cmd_t;

  // Per-transaction controls shared by all four channel units.
  typedef struct packed {
    logic [CMD_W-1:0]          cmd;
    logic                      a_full;
    logic                      b_full;
    logic signed [SCALE_W-1:0] scale;
    logic [RATIO_W-1:0]        ratio;
  } chan_ctl_t;

endpackage

// ===== rtl/core/rgba8_saturating_color_alu_top.sv =====
// Top level of the RGBA8 saturating color ALU: input register, channel units, result register.
//
//   Channel  Ports       Payload
//   input    in_t*       tdata: A rgba, B rgba, scale_factor, blend_ratio; tuser: command
//   result   out_t*      tdata: red, green, blue, alpha; tuser: colors_equal
//
// One transaction is accepted per clock while in_tready is high; each accepted transaction
// passes through the input register and the result register around the channel units.
// While a result waits, one more transaction is held in the input register; in_tready
// drops only when both registers are full and out_tready is low.
// rst_n clears both valid flags; payload registers are not reset.
`timescale 1ns / 1ps
`include "rgba8_saturating_color_alu_top_assert.svh"

module rgba8_saturating_color_alu_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // a_red, a_green, a_blue, a_alpha, b_red, b_green, b_blue, b_alpha,
  // scale_factor, blend_ratio, zero fill
  input  logic [rgba8_alu_pkg::IN_DATA_W-1:0]  in_tdata,
  // command
  input  logic [rgba8_alu_pkg::CMD_W-1:0]      in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // out_red, out_green, out_blue, out_alpha
  output logic [rgba8_alu_pkg::OUT_DATA_W-1:0] out_tdata,
  // colors_equal
  output logic [0:0]  out_tuser
);
  import rgba8_alu_pkg::*;

  logic                  s1_valid_r;
  logic                  s1_valid_nxt;
  logic [IN_DATA_W-1:0]  s1_data_r;
  logic [CMD_W-1:0]      s1_cmd_r;
  logic                  s1_go;
  logic                  out_valid_r;
  logic                  out_valid_nxt;
  logic [OUT_DATA_W-1:0] out_data_r;
  logic                  out_eq_r;

  logic [CHAN_W-1:0]     a_ch   [NUM_CHAN];
  logic [CHAN_W-1:0]     b_ch   [NUM_CHAN];
  logic [CHAN_W-1:0]     res_ch [NUM_CHAN];
  logic [OUT_DATA_W-1:0] res_word;
  logic                  eq_w;
  chan_ctl_t             ctl;

  // The input stage moves on whenever the result register is empty or being read.
  assign s1_go     = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || s1_go;

  assign s1_valid_nxt  = (in_tvalid && in_tready) ? 1'b1 : (s1_go ? 1'b0 : s1_valid_r);
  assign out_valid_nxt = s1_go ? 1'b1 : (out_tready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      s1_data_r <= in_tdata;
      s1_cmd_r  <= in_tuser;
    end
    if (s1_go) begin
      out_data_r <= res_word;
      out_eq_r   <= eq_w;
    end
  end

  always_comb begin
    for (int i = 0; i < NUM_CHAN; i++) begin
      a_ch[i] = s1_data_r[A_LSB + CHAN_W*i +: CHAN_W];
      b_ch[i] = s1_data_r[B_LSB + CHAN_W*i +: CHAN_W];
    end
  end

  assign eq_w = (s1_data_r[A_LSB +: 32] == s1_data_r[B_LSB +: 32]);

  assign ctl.cmd    = s1_cmd_r;
  assign ctl.a_full = &s1_data_r[A_LSB +: 32];
  assign ctl.b_full = &s1_data_r[B_LSB +: 32];
  assign ctl.scale  = $signed(s1_data_r[SCALE_LSB +: SCALE_W]);
  assign ctl.ratio  = s1_data_r[RATIO_LSB +: RATIO_W];

  for (genvar g = 0; g < NUM_CHAN; g++) begin : g_chan
    rgba8_alu_chan u_chan (
      .a   (a_ch[g]),
      .b   (b_ch[g]),
      .ctl (ctl),
      .res (res_ch[g])
    );
    assign res_word[CHAN_W*g +: CHAN_W] = res_ch[g];
  end

  assign out_tvalid   = out_valid_r;
  assign out_tdata    = out_data_r;
  assign out_tuser[0] = out_eq_r;

  `RGBA_ASSERT_SAME(a_full_stall_blocks_input,
    s1_valid_r && out_valid_r && !out_tready, !in_tready,
    "input accepted while both stages were full and stalled")
  `RGBA_ASSERT_NEXT(a_accept_fills_stage,
    in_tvalid && in_tready, s1_valid_r,
    "accepted transaction did not reach the input register")
  `RGBA_ASSERT_SAME(a_sub_equal_is_zero,
    s1_valid_r && eq_w && (s1_cmd_r == CMD_SUB), res_word == '0,
    "subtract of equal colors gave a nonzero result")
  `RGBA_ASSERT_SAME(a_mod_full_a_gives_b,
    s1_valid_r && ctl.a_full && (s1_cmd_r == CMD_MOD),
    res_word == s1_data_r[B_LSB +: 32],
    "modulate with full A did not return B")

endmodule

// ===== rtl/core/rgba8_alu_chan.sv =====
// One color channel of the ALU: add, subtract, modulate, scale and blend.
`timescale 1ns / 1ps

module rgba8_alu_chan (
  input  logic [7:0]               a,
  input  logic [7:0]               b,
  input  rgba8_alu_pkg::chan_ctl_t ctl,
  output logic [7:0]               res
);
  import rgba8_alu_pkg::*;

  logic [8:0]         add_sum;
  logic [16:0]        mod_prod;
  logic [16:0]        mod_less;
  logic signed [24:0] scl_prod;
  logic [8:0]         blend_w;
  logic [16:0]        blend_ta;
  logic [15:0]        blend_tb;
  logic [8:0]         blend_sum;

  assign add_sum  = {1'b0, a} + {1'b0, b};
  assign mod_prod = {8'd0, {1'b0, a} + 9'd1} * {8'd0, {1'b0, b} + 9'd1};
  assign mod_less = mod_prod - 17'd1;
  assign scl_prod = $signed({16'd0, a}) * 25'(ctl.scale);
  assign blend_w  = 9'd256 - {1'b0, ctl.ratio[7:0]};
  assign blend_ta = {8'd0, a} * {8'd0, blend_w};
  assign blend_tb = {8'd0, b} * {8'd0, ctl.ratio[7:0]};
  // Both truncated terms are at most 255, so the sum fits in nine bits.
  assign blend_sum = {1'b0, blend_ta[15:8]} + {1'b0, blend_tb[15:8]};

  always_comb begin
    res = a;
    case (ctl.cmd)
      CMD_ADD: begin
        res = add_sum[8] ? CHAN_MAX : add_sum[7:0];
      end
      CMD_SUB: begin
        res = (a > b) ? a - b : 8'd0;
      end
      CMD_MOD: begin
        if (ctl.a_full) begin
          res = b;
        end else if (ctl.b_full) begin
          res = a;
        end else begin
          res = mod_less[15:8];
        end
      end
      CMD_SCALE: begin
        // A product at or below zero clamps to zero; the sign is tested on the full product.
        if (scl_prod <= 25'sd0) begin
          res = 8'd0;
        end else if (scl_prod[23:16] != 8'd0) begin
          res = CHAN_MAX;
        end else begin
          res = scl_prod[15:8];
        end
      end
      CMD_BLEND: begin
        if (ctl.ratio == 9'd0) begin
          res = a;
        end else if (ctl.ratio[8]) begin
          res = b;
        end else begin
          res = blend_sum[8] ? CHAN_MAX : blend_sum[7:0];
        end
      end
      default: begin
        res = a;
      end
    endcase
  end

endmodule

// ===== dv/tb.sv =====
// Self-checking testbench for the RGBA8 saturating color ALU stream top level.
`timescale 1ns / 1ps

module tb;
  import rgba8_alu_pkg::*;

  localparam int unsigned FILL_W      = IN_DATA_W - (RATIO_LSB + RATIO_W);
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned MAX_REPORTS = 10;
  localparam int unsigned TAIL_CYCLES = 12;

  // Command codes outside the enumerated set; the block passes A through for these.
  localparam logic [CMD_W-1:0] CMD_SPARE_LO  = 3'd5;
  localparam logic [CMD_W-1:0] CMD_SPARE_MID = 3'd6;
  localparam logic [CMD_W-1:0] CMD_SPARE_HI  = 3'd7;

  typedef struct packed {
    logic [CMD_W-1:0]                 cmd;
    logic [NUM_CHAN-1:0][CHAN_W-1:0]  a_col;
    logic [NUM_CHAN-1:0][CHAN_W-1:0]  b_col;
    logic signed [SCALE_W-1:0]        scale;
    logic [RATIO_W-1:0]               ratio;
  } pixel_req_t;

  typedef struct packed {
    logic [NUM_CHAN-1:0][CHAN_W-1:0]  col;
    logic                             same;
  } pixel_res_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_DATA_W-1:0] in_tdata = '0;
  logic [CMD_W-1:0] in_tuser = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [0:0] out_tuser;

  pixel_req_t  pending_q[$];
  pixel_res_t  expected_q[$];
  pixel_req_t  sent_req;
  pixel_res_t  want_res;
  int unsigned error_count = 0;
  int unsigned cycle_count = 0;
  int unsigned gap_left = 0;
  int unsigned stall_left = 0;
  bit          quiet = 1'b0;

  rgba8_saturating_color_alu_top uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  function automatic logic [CHAN_W-1:0] sat_chan(int unsigned v);
    return (v > CHAN_MAX) ? CHAN_MAX : v[CHAN_W-1:0];
  endfunction

  // Expected color and equality flag for one input transaction.
  function automatic pixel_res_t color_op(pixel_req_t r);
    pixel_res_t  res;
    int unsigned av, bv, t1, t2;
    int          prod;
    logic        a_full, b_full;
    a_full   = (r.a_col == '1);
    b_full   = (r.b_col == '1);
    res.same = (r.a_col == r.b_col);
    for (int i = 0; i < NUM_CHAN; i++) begin
      av = r.a_col[i];
      bv = r.b_col[i];
      case (r.cmd)
        CMD_ADD: res.col[i] = sat_chan(av + bv);
        CMD_SUB: res.col[i] = (av > bv) ? CHAN_W'(av - bv) : '0;
        CMD_MOD: begin
          if (a_full) res.col[i] = bv[CHAN_W-1:0];
          else if (b_full) res.col[i] = av[CHAN_W-1:0];
          else res.col[i] = CHAN_W'((((av + 1) * (bv + 1)) - 1) >> 8);
        end
        CMD_SCALE: begin
          prod = int'(av) * int'($signed(r.scale));
          res.col[i] = (prod <= 0) ? '0 : sat_chan(prod >>> 8);
        end
        CMD_BLEND: begin
          if (r.ratio == 0) res.col[i] = av[CHAN_W-1:0];
          else if (r.ratio >= 256) res.col[i] = bv[CHAN_W-1:0];
          else begin
            t1 = (av * (256 - r.ratio)) >> 8;
            t2 = (bv * r.ratio) >> 8;
            res.col[i] = sat_chan(t1 + t2);
          end
        end
        default: res.col[i] = av[CHAN_W-1:0];
      endcase
    end
    return res;
  endfunction

  function automatic pixel_req_t make_req(logic [CMD_W-1:0] cmd, logic [31:0] a,
                                          logic [31:0] b, logic [15:0] scale,
                                          logic [8:0] ratio);
    pixel_req_t r;
    r.cmd   = cmd;
    r.a_col = a;
    r.b_col = b;
    r.scale = scale;
    r.ratio = ratio;
    return r;
  endfunction

  // Channel values lean toward the clamp points so saturation paths get hit often.
  function automatic logic [CHAN_W-1:0] rand_chan();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return CHAN_MAX;
      default: return CHAN_W'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic pixel_req_t rand_req();
    pixel_req_t r;
    int unsigned pick;
    for (int i = 0; i < NUM_CHAN; i++) begin
      r.a_col[i] = rand_chan();
      r.b_col[i] = rand_chan();
    end
    pick = $urandom_range(0, 9);
    if (pick == 0) r.b_col = r.a_col;
    else if (pick == 1) r.a_col = '1;
    else if (pick == 2) r.b_col = '1;
    pick = $urandom_range(0, 15);
    if (pick == 0) r.cmd = CMD_W'($urandom_range(CMD_SPARE_LO, CMD_SPARE_HI));
    else r.cmd = CMD_W'($urandom_range(CMD_ADD, CMD_BLEND));
    case ($urandom_range(0, 3))
      0: r.scale = SCALE_W'($urandom_range(0, 1023));
      1: r.scale = -SCALE_W'($urandom_range(0, 1023));
      default: r.scale = SCALE_W'($urandom());
    endcase
    pick = $urandom_range(0, 11);
    if (pick == 0) r.ratio = '0;
    else if (pick == 1) r.ratio = 9'd256;
    else if (pick == 2) r.ratio = RATIO_W'($urandom_range(257, 511));
    else r.ratio = RATIO_W'($urandom_range(1, 255));
    return r;
  endfunction

  task automatic note_mismatch(string what, int unsigned want, int unsigned got);
    if (error_count < MAX_REPORTS)
      $display("mismatch %s: expected %0d, got %0d", what, want, got);
    error_count++;
  endtask

  // Sampled at the falling edge so the check never races the clocked processes.
  task automatic wait_drained();
    while (pending_q.size() != 0 || in_tvalid || expected_q.size() != 0)
      @(negedge clk);
  endtask

  // Driver: one transaction per clock when not idling and in_tready is high, taken from pending_q.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready)
        expected_q.push_back(color_op(sent_req));
      if (!in_tvalid || in_tready) begin
        if (gap_left > 0 && !quiet) begin
          gap_left--;
          in_tvalid <= 1'b0;
        end else if (pending_q.size() != 0) begin
          sent_req = pending_q.pop_front();
          in_tdata <= {{FILL_W{1'b0}}, sent_req.ratio, sent_req.scale,
                       sent_req.b_col, sent_req.a_col};
          in_tuser <= sent_req.cmd;
          in_tvalid <= 1'b1;
          if (!quiet && $urandom_range(0, 5) == 0)
            gap_left = $urandom_range(1, 7);
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each accepted result against the oldest expectation.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (expected_q.size() == 0) begin
          if (error_count < MAX_REPORTS)
            $display("result transaction with nothing expected: tdata %h", out_tdata);
          error_count++;
        end else begin
          want_res = expected_q.pop_front();
          for (int i = 0; i < NUM_CHAN; i++)
            if (out_tdata[i*CHAN_W +: CHAN_W] !== want_res.col[i])
              note_mismatch($sformatf("channel %0d", i), want_res.col[i],
                            out_tdata[i*CHAN_W +: CHAN_W]);
          if (out_tuser[0] !== want_res.same)
            note_mismatch("colors_equal", want_res.same, out_tuser[0]);
        end
      end
      if (stall_left > 0 && !quiet) begin
        stall_left--;
        out_tready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(0, 6);
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed corners: clamps, full operands, scale extremes, blend end points.
    pending_q.push_back(make_req(CMD_ADD, 32'h0000_0000, 32'h0000_0000, 16'h0000, 9'd0));
    pending_q.push_back(make_req(CMD_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 9'h1FF));
    pending_q.push_back(make_req(CMD_ADD, 32'h80FF_017F, 32'h8001_FF80, 16'h0100, 9'd0));
    pending_q.push_back(make_req(CMD_SUB, 32'h1020_30FF, 32'h2010_30FE, 16'h0000, 9'd0));
    pending_q.push_back(make_req(CMD_SUB, 32'h0000_0000, 32'hFFFF_FFFF, 16'h0000, 9'd0));
    pending_q.push_back(make_req(CMD_MOD, 32'hFFFF_FFFF, 32'h1234_5678, 16'h0000, 9'd0));
    pending_q.push_back(make_req(CMD_MOD, 32'h9ABC_DEF0, 32'hFFFF_FFFF, 16'h0000, 9'd0));
    pending_q.push_back(make_req(CMD_MOD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'h0000, 9'd0));
    pending_q.push_back(make_req(CMD_MOD, 32'h80FF_0040, 32'h8000_FFC0, 16'h0000, 9'd0));
    pending_q.push_back(make_req(CMD_SCALE, 32'hFF80_01C0, 32'h0, 16'h7FFF, 9'd0));
    pending_q.push_back(make_req(CMD_SCALE, 32'hFF80_01C0, 32'h0, 16'h8000, 9'd0));
    pending_q.push_back(make_req(CMD_SCALE, 32'hFF80_01C0, 32'h0, 16'h0100, 9'd0));
    pending_q.push_back(make_req(CMD_SCALE, 32'hFF80_01C0, 32'h0, 16'hFFFF, 9'd0));
    pending_q.push_back(make_req(CMD_SCALE, 32'hFF80_01C3, 32'h0, 16'h0080, 9'd0));
    pending_q.push_back(make_req(CMD_SCALE, 32'hFF80_0103, 32'h0, 16'h0001, 9'd0));
    pending_q.push_back(make_req(CMD_BLEND, 32'h1122_33FF, 32'hEEDD_CC00, 16'h0000, 9'd0));
    pending_q.push_back(make_req(CMD_BLEND, 32'h1122_33FF, 32'hEEDD_CC00, 16'h0000, 9'd256));
    pending_q.push_back(make_req(CMD_BLEND, 32'h1122_33FF, 32'hEEDD_CC00, 16'h0000, 9'd257));
    pending_q.push_back(make_req(CMD_BLEND, 32'h1122_33FF, 32'hEEDD_CC00, 16'h0000, 9'h1FF));
    pending_q.push_back(make_req(CMD_BLEND, 32'hFFFF_FF00, 32'hFF00_FFFF, 16'h0000, 9'd1));
    pending_q.push_back(make_req(CMD_BLEND, 32'hFFFF_FF00, 32'hFF00_FFFF, 16'h0000, 9'd128));
    pending_q.push_back(make_req(CMD_BLEND, 32'hFFFF_FF00, 32'hFF00_FFFF, 16'h0000, 9'd255));
    pending_q.push_back(make_req(CMD_SPARE_LO, 32'hA5A5_5A5A, 32'h0F0F_F0F0, 16'h1234, 9'd3));
    pending_q.push_back(make_req(CMD_SPARE_MID, 32'h5A5A_A5A5, 32'h5A5A_A5A5, 16'hFEDC,
                                 9'd100));
    pending_q.push_back(make_req(CMD_SPARE_HI, 32'h0102_0304, 32'h0102_0304, 16'h0000, 9'd0));
    wait_drained();

    repeat (300) pending_q.push_back(rand_req());
    wait_drained();
    // A stretch with no idling on either side.
    quiet = 1'b1;
    repeat (100) pending_q.push_back(rand_req());
    wait_drained();
    quiet = 1'b0;
    repeat (100) pending_q.push_back(rand_req());
    // The sender holds back here until every result is in.
    wait_drained();
    quiet = 1'b1;
    repeat (100) pending_q.push_back(rand_req());
    wait_drained();
    repeat (TAIL_CYCLES) @(negedge clk);

    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/rgba8_alu_pkg.sv
rtl/core/rgba8_alu_chan.sv
rtl/core/rgba8_saturating_color_alu_top.sv
dv/tb.sv
